>>> hdl/stc_pkg.sv
// Shared types and register indexes for the sensor compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package stc_pkg;

	// Calibration register indexes
	localparam logic [2:0] CFG_T1_T2 = 3'd0;
	localparam logic [2:0] CFG_T3_P1 = 3'd1;
	localparam logic [2:0] CFG_P2_P3 = 3'd2;
	localparam logic [2:0] CFG_P4_P5 = 3'd3;
	localparam logic [2:0] CFG_P6_P7 = 3'd4;
	localparam logic [2:0] CFG_P8_P9 = 3'd5;

	// Calibration words, split out of the six registers
	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// Temperature section to pressure section
	typedef struct packed {
		logic        [15:0] tc;
		logic signed [25:0] pv;
		logic        [19:0] ap;
	} tmp_out_t;

	// Pressure front end to divider
	typedef struct packed {
		logic [63:0] mag;
		logic [30:0] dvs;
		logic        neg;
		logic        dz;
		logic [15:0] tc;
	} div_in_t;

	// Divider to pressure back end
	typedef struct packed {
		logic [63:0] quo;
		logic        neg;
		logic        dz;
		logic [15:0] tc;
	} div_out_t;

endpackage
`default_nettype wire

>>> hdl/sensor_temp_pressure_compensation.sv
// Top level of the temperature and pressure compensation pipeline.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  in       | in_valid / in_ready    | raw_temperature[19:0], raw_pressure[19:0]
//  out      | out_valid / out_ready  | temperature_centi[15:0], pressure_q24_8[31:0],
//           |                        | divisor_zero
//  cfg      | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[31:0]
//
// One pair enters per cycle while in_ready is high; each result passes through
// 5 temperature stages, 6 pressure front-end stages, 32 divider stages at
// two quotient bits each, and 6 back-end stages whose last is the output
// register. Reset clears all valid bits and the calibration registers.
// A held result freezes every stage together, so nothing is dropped or repeated;
// in_ready falls only while the output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none
module sensor_temp_pressure_compensation
	import stc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] temperature_centi,
	output logic [31:0]      pressure_q24_8,
	output logic             divisor_zero,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] t1_t2_q, t3_p1_q, p2_p3_q, p4_p5_q, p6_p7_q, p8_p9_q;
	cal_t        cal;
	logic        adv;
	logic        tmp_vld, pre_vld, div_vld;
	tmp_out_t    tmp_dat;
	div_in_t     pre_dat;
	div_out_t    div_dat;

	// calibration writes; indexes past the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_t2_q <= 32'd0;
			t3_p1_q <= 32'd0;
			p2_p3_q <= 32'd0;
			p4_p5_q <= 32'd0;
			p6_p7_q <= 32'd0;
			p8_p9_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_T1_T2: t1_t2_q <= cfg_data;
				CFG_T3_P1: t3_p1_q <= cfg_data;
				CFG_P2_P3: p2_p3_q <= cfg_data;
				CFG_P4_P5: p4_p5_q <= cfg_data;
				CFG_P6_P7: p6_p7_q <= cfg_data;
				CFG_P8_P9: p8_p9_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// split the registers into the twelve coefficients
	assign cal.t1 = t1_t2_q[15:0];
	assign cal.t2 = $signed(t1_t2_q[31:16]);
	assign cal.t3 = $signed(t3_p1_q[15:0]);
	assign cal.p1 = t3_p1_q[31:16];
	assign cal.p2 = $signed(p2_p3_q[15:0]);
	assign cal.p3 = $signed(p2_p3_q[31:16]);
	assign cal.p4 = $signed(p4_p5_q[15:0]);
	assign cal.p5 = $signed(p4_p5_q[31:16]);
	assign cal.p6 = $signed(p6_p7_q[15:0]);
	assign cal.p7 = $signed(p6_p7_q[31:16]);
	assign cal.p8 = $signed(p8_p9_q[15:0]);
	assign cal.p9 = $signed(p8_p9_q[31:16]);

	// advance the whole pipe unless a finished result is held at the output
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	stc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.vld_i           (in_valid),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.cal             (cal),
		.vld_o           (tmp_vld),
		.dat_o           (tmp_dat)
	);

	stc_pre u_pre (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (tmp_vld),
		.dat_i  (tmp_dat),
		.cal    (cal),
		.vld_o  (pre_vld),
		.dat_o  (pre_dat)
	);

	stc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (pre_vld),
		.dat_i  (pre_dat),
		.vld_o  (div_vld),
		.dat_o  (div_dat)
	);

	stc_post u_post (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.vld_i             (div_vld),
		.dat_i             (div_dat),
		.cal               (cal),
		.vld_o             (out_valid),
		.temperature_centi (temperature_centi),
		.pressure_q24_8    (pressure_q24_8),
		.divisor_zero      (divisor_zero)
	);

endmodule
`default_nettype wire

>>> hdl/stc_temp.sv
// Temperature compensation stages: fine value, centidegree result, pressure offset.
`timescale 1ns / 1ps
`default_nettype none
module stc_temp
	import stc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        vld_i,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	input  wire cal_t        cal,
	output logic             vld_o,
	output tmp_out_t         dat_o
);

	localparam logic signed [25:0] TOff = 26'sd128000;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [17:0]  a_s1;
	logic signed [16:0]  d_s1;
	logic signed [33:0]  ta_s2, dd_s2;
	logic signed [22:0]  v1t_s3;
	logic signed [37:0]  m_s3;
	logic signed [24:0]  tf_s4;
	logic        [15:0]  tc_s5;
	logic signed [25:0]  pv_s5;
	logic        [19:0]  ap_s1, ap_s2, ap_s3, ap_s4, ap_s5;

	logic signed [33:0]  tsh, xsh;
	logic signed [21:0]  xs;
	logic signed [37:0]  msh;
	logic signed [27:0]  tt;
	logic signed [19:0]  t8;
	logic        [15:0]  tc_n;

	always_comb begin
		tsh = ta_s2 >>> 11;
		xsh = dd_s2 >>> 12;
		xs  = xsh[21:0];
		msh = m_s3 >>> 14;
		tt  = $signed({{3{tf_s4[24]}}, tf_s4}) * 28'sd5 + 28'sd128;
		t8  = tt[27:8];
		if (t8 > 20'sd32767) begin
			tc_n = 16'h7FFF;
		end else if (t8 < -20'sd32768) begin
			tc_n = 16'h8000;
		end else begin
			tc_n = t8[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1   <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
			d_s1   <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
			ap_s1  <= raw_pressure;
			ta_s2  <= a_s1 * $signed(cal.t2);
			dd_s2  <= d_s1 * d_s1;
			ap_s2  <= ap_s1;
			v1t_s3 <= tsh[22:0];
			m_s3   <= xs * $signed(cal.t3);
			ap_s3  <= ap_s2;
			tf_s4  <= $signed({{2{v1t_s3[22]}}, v1t_s3}) + $signed(msh[24:0]);
			ap_s4  <= ap_s3;
			tc_s5  <= tc_n;
			pv_s5  <= $signed({tf_s4[24], tf_s4}) - TOff;
			ap_s5  <= ap_s4;
		end
	end

	assign vld_o    = v_s5;
	assign dat_o.tc = tc_s5;
	assign dat_o.pv = pv_s5;
	assign dat_o.ap = ap_s5;

endmodule
`default_nettype wire

>>> hdl/stc_pre.sv
// Pressure front end: polynomial terms, dividend and divisor magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module stc_pre
	import stc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     vld_i,
	input  wire tmp_out_t dat_i,
	input  wire cal_t     cal,
	output logic          vld_o,
	output div_in_t       dat_o
);

	localparam logic [20:0] PBase    = 21'd1048576;
	localparam logic [11:0] DivScale = 12'd3125;

	logic                v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic signed [51:0]  sq_s6;
	logic signed [41:0]  pp5_s6, pp2_s6, pp5_s7, pp2_s7;
	logic        [63:0]  a6_s7, a3_s7, v2_s8, v1a_s8, num_s9, b_s9, nm_s10, bm_s10;
	logic        [19:0]  ap_s6, ap_s7, ap_s8;
	logic        [15:0]  tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	div_in_t             out_s11;

	logic signed [67:0]  t6, t3;
	logic        [63:0]  e5, e2, p4e;
	logic signed [63:0]  a3sh, bsh;
	logic        [20:0]  pr;
	logic        [75:0]  tn;
	logic        [79:0]  tb;
	logic signed [30:0]  dv;

	always_comb begin
		t6   = sq_s6 * $signed(cal.p6);
		t3   = sq_s6 * $signed(cal.p3);
		e5   = {{22{pp5_s7[41]}}, pp5_s7};
		e2   = {{22{pp2_s7[41]}}, pp2_s7};
		p4e  = {{48{cal.p4[15]}}, cal.p4};
		a3sh = $signed(a3_s7) >>> 8;
		pr   = PBase - {1'b0, ap_s8};
		tn   = num_s9 * DivScale;
		tb   = b_s9 * cal.p1;
		bsh  = $signed(bm_s10) >>> 33;
		dv   = bsh[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s6  <= vld_i;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s6   <= dat_i.pv * dat_i.pv;
			pp5_s6  <= dat_i.pv * $signed(cal.p5);
			pp2_s6  <= dat_i.pv * $signed(cal.p2);
			ap_s6   <= dat_i.ap;
			tc_s6   <= dat_i.tc;
			a6_s7   <= t6[63:0];
			a3_s7   <= t3[63:0];
			pp5_s7  <= pp5_s6;
			pp2_s7  <= pp2_s6;
			ap_s7   <= ap_s6;
			tc_s7   <= tc_s6;
			v2_s8   <= a6_s7 + (e5 << 17) + (p4e << 35);
			v1a_s8  <= $unsigned(a3sh) + (e2 << 12);
			ap_s8   <= ap_s7;
			tc_s8   <= tc_s7;
			num_s9  <= ({43'd0, pr} << 31) - v2_s8;
			b_s9    <= (64'd1 << 47) + v1a_s8;
			tc_s9   <= tc_s8;
			nm_s10  <= tn[63:0];
			bm_s10  <= tb[63:0];
			tc_s10  <= tc_s9;
			// fold signs out; the divider works on magnitudes
			out_s11.mag <= nm_s10[63] ? (64'd0 - nm_s10) : nm_s10;
			out_s11.dvs <= dv[30] ? (31'd0 - $unsigned(dv)) : $unsigned(dv);
			out_s11.neg <= nm_s10[63] ^ dv[30];
			out_s11.dz  <= (dv == 31'sd0);
			out_s11.tc  <= tc_s10;
		end
	end

	assign vld_o = v_s11;
	assign dat_o = out_s11;

endmodule
`default_nettype wire

>>> hdl/stc_div.sv
// Pipelined restoring divider, two quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module stc_div
	import stc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    adv,
	input  wire logic    vld_i,
	input  wire div_in_t dat_i,
	output logic         vld_o,
	output div_out_t     dat_o
);

	localparam int Steps = 32;

	logic        [29:0] rem_s [1:Steps];
	logic        [63:0] nq_s  [1:Steps];
	logic        [30:0] dvs_s [1:Steps];
	logic        [15:0] tc_s  [1:Steps];
	logic        [Steps:1] vld_s, neg_s, dz_s;

	for (genvar g = 0; g < Steps; g++) begin : g_stage
		logic [29:0] r_in, r1, r2;
		logic [63:0] n_in;
		logic [30:0] d_in, w1, w2;
		logic [15:0] tc_in;
		logic        v_in, neg_in, dz_in, q1, q2;

		if (g == 0) begin : g_first
			assign r_in   = 30'd0;
			assign n_in   = dat_i.mag;
			assign d_in   = dat_i.dvs;
			assign tc_in  = dat_i.tc;
			assign v_in   = vld_i;
			assign neg_in = dat_i.neg;
			assign dz_in  = dat_i.dz;
		end else begin : g_next
			assign r_in   = rem_s[g];
			assign n_in   = nq_s[g];
			assign d_in   = dvs_s[g];
			assign tc_in  = tc_s[g];
			assign v_in   = vld_s[g];
			assign neg_in = neg_s[g];
			assign dz_in  = dz_s[g];
		end

		// shift in one dividend bit, subtract where it fits; twice
		always_comb begin
			w1 = {r_in, n_in[63]};
			q1 = (w1 >= d_in);
			r1 = q1 ? 30'(w1 - d_in) : w1[29:0];
			w2 = {r1, n_in[62]};
			q2 = (w2 >= d_in);
			r2 = q2 ? 30'(w2 - d_in) : w2[29:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s[g+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g+1] <= r2;
				nq_s[g+1]  <= {n_in[61:0], q1, q2};
				dvs_s[g+1] <= d_in;
				tc_s[g+1]  <= tc_in;
				neg_s[g+1] <= neg_in;
				dz_s[g+1]  <= dz_in;
			end
		end
	end

	assign vld_o     = vld_s[Steps];
	assign dat_o.quo = nq_s[Steps];
	assign dat_o.neg = neg_s[Steps];
	assign dat_o.dz  = dz_s[Steps];
	assign dat_o.tc  = tc_s[Steps];

endmodule
`default_nettype wire

>>> hdl/stc_post.sv
// Pressure back end: quotient sign, correction terms, saturation, output register.
`timescale 1ns / 1ps
`default_nettype none
module stc_post
	import stc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        vld_i,
	input  wire div_out_t    dat_i,
	input  wire cal_t        cal,
	output logic             vld_o,
	output logic signed [15:0] temperature_centi,
	output logic [31:0]      pressure_q24_8,
	output logic             divisor_zero
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        [63:0] q_s1, q_s2, q_s3, q_s4;
	logic        [63:0] q13_s2, m9_s2, v8_s2;
	logic        [63:0] pp0_s3, v2b_s3, v2b_s4, v1b_s4, s_s5;
	logic        [31:0] pp1_s3, pp2_s3;
	logic        [15:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6;
	logic               dz_s1, dz_s2, dz_s3, dz_s4, dz_s5, dz_s6;
	logic        [31:0] pres_s6;

	logic signed [63:0] q13, v8sh, prsh, ssh, pf;
	logic signed [79:0] t9, t8;
	logic        [63:0] pa, p1x, p2x, prod, p7e;
	logic        [31:0] pres_n;

	always_comb begin
		q13  = $signed(q_s1) >>> 13;
		t9   = q13 * $signed(cal.p9);
		t8   = $signed(q_s1) * $signed(cal.p8);
		pa   = m9_s2[31:0] * q13_s2[31:0];
		p1x  = m9_s2[31:0] * q13_s2[63:32];
		p2x  = m9_s2[63:32] * q13_s2[31:0];
		v8sh = $signed(v8_s2) >>> 19;
		prod = pp0_s3 + {32'(pp1_s3 + pp2_s3), 32'd0};
		prsh = $signed(prod) >>> 25;
		ssh  = $signed(s_s5) >>> 8;
		p7e  = {{48{cal.p7[15]}}, cal.p7};
		pf   = ssh + $signed(p7e << 4);
		// clamp to the unsigned 32-bit range
		if (pf[63]) begin
			pres_n = 32'd0;
		end else if (pf[63:32] != 32'd0) begin
			pres_n = 32'hFFFF_FFFF;
		end else begin
			pres_n = pf[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1    <= dat_i.neg ? (64'd0 - dat_i.quo) : dat_i.quo;
			tc_s1   <= dat_i.tc;
			dz_s1   <= dat_i.dz;
			q_s2    <= q_s1;
			q13_s2  <= q13;
			m9_s2   <= t9[63:0];
			v8_s2   <= t8[63:0];
			tc_s2   <= tc_s1;
			dz_s2   <= dz_s1;
			q_s3    <= q_s2;
			pp0_s3  <= pa;
			pp1_s3  <= p1x[31:0];
			pp2_s3  <= p2x[31:0];
			v2b_s3  <= v8sh;
			tc_s3   <= tc_s2;
			dz_s3   <= dz_s2;
			q_s4    <= q_s3;
			v1b_s4  <= prsh;
			v2b_s4  <= v2b_s3;
			tc_s4   <= tc_s3;
			dz_s4   <= dz_s3;
			s_s5    <= q_s4 + v1b_s4 + v2b_s4;
			tc_s5   <= tc_s4;
			dz_s5   <= dz_s4;
			pres_s6 <= dz_s5 ? 32'd0 : pres_n;
			tc_s6   <= tc_s5;
			dz_s6   <= dz_s5;
		end
	end

	assign vld_o             = v_s6;
	assign temperature_centi = $signed(tc_s6);
	assign pressure_q24_8    = pres_s6;
	assign divisor_zero      = dz_s6;

endmodule
`default_nettype wire
